FILE: hw/rtl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg - shared types and constants for the rational arithmetic unit
// Payload structs, operation and status codes, and the queue entry type.
// ----------------------------------------------------------------------------
package rau_pkg;

	localparam int OperandWidthDefault = 32;
	localparam int FieldWidth = 32;
	localparam int MagWidth = 64;
	localparam int QueueDepthDefault = 2;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_ZERO_DEN = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]         op;
		logic signed [31:0] a_num;
		logic signed [31:0] a_den;
		logic signed [31:0] b_num;
		logic signed [31:0] b_den;
	} in_item_t;

	typedef struct packed {
		logic signed [63:0] res_num;
		logic [62:0]        res_den;
		logic [1:0]         status;
	} out_item_t;

	// unreduced fraction handed from front to back
	typedef struct packed {
		logic        neg;
		logic [63:0] num_mag;
		logic [63:0] den_mag;
	} frac_t;

endpackage

FILE: hw/rtl/rational_arith_unit.sv
// ----------------------------------------------------------------------------
// rational_arith_unit - exact fraction add/sub/mul/div with gcd reduction
// Front computes cross products, queue decouples, back reduces to lowest terms.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : in_valid / in_stall / in_data (op, a_num, a_den, b_num, b_den).
//   out channel : out_valid / out_stall / out_data (res_num, res_den, status).
//   A transfer happens on a clock edge with valid high and stall low.
// Sequence: the front forms two products for mul/div and three for add/sub
//   (shared 33x33 multiplier, steps S_M0, S_M1, S_M2) up to the queue
//   write; the back picks the entry up from the queue when idle and runs
//   the binary gcd loop, two restoring divisions and formatting (B_FIN,
//   B_OUT). Zero numerator or zero denominator skips gcd and division.
// Throughput: the back takes a new item only once it is back in idle;
//   items skipping reduction pass at the pace of the front. The front
//   fetches the next item while the back is busy and a two-entry queue
//   holds finished cross products.
// Reset: arst_n clears all control state; queue empties, no results pending.
// Stalls: a stalled result holds steady in the back's output register, the
//   back stops, the queue fills and the front waits in S_OUT, in_stall high.
// ----------------------------------------------------------------------------
module rational_arith_unit #(
	parameter int OPERAND_WIDTH = rau_pkg::OperandWidthDefault,
	parameter int QUEUE_DEPTH   = rau_pkg::QueueDepthDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  rau_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output rau_pkg::out_item_t out_data
);

	// front to queue
	logic           f_valid, f_stall;
	rau_pkg::frac_t f_data;
	// queue to back
	logic           q_valid, q_stall;
	rau_pkg::frac_t q_data;

	rau_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
		.clk, .arst_n,
		.in_valid, .in_stall, .in_data,
		.f_valid, .f_stall, .f_data
	);

	rau_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk, .arst_n,
		.w_valid(f_valid), .w_stall(f_stall), .w_data(f_data),
		.r_valid(q_valid), .r_stall(q_stall), .r_data(q_data)
	);

	rau_back u_back (
		.clk, .arst_n,
		.q_valid, .q_stall, .q_data,
		.out_valid, .out_stall, .out_data
	);

endmodule

FILE: hw/rtl/rau_front.sv
// ----------------------------------------------------------------------------
// rau_front - operand decode and cross products
// Sign-extends operands, forms the unreduced fraction in steps S_M0, S_M1
// (and S_M2 for add/sub) using one shared 33x33 signed multiplier.
// ----------------------------------------------------------------------------
module rau_front #(
	parameter int OPERAND_WIDTH = rau_pkg::OperandWidthDefault
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  rau_pkg::in_item_t in_data,
	output logic              f_valid,
	input  logic              f_stall,
	output rau_pkg::frac_t    f_data
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_M0   = 5'b00010,
		S_M1   = 5'b00100,
		S_M2   = 5'b01000,
		S_OUT  = 5'b10000
	} fst_t;

	fst_t state_q;
	logic [1:0] op_q;
	logic signed [32:0] an_q, ad_q, bn_q, bd_q;
	logic signed [32:0] mx, my;
	logic signed [65:0] prod;
	logic signed [65:0] p0_q, p1_q, p2_q;
	logic signed [65:0] num_s, den_s;
	rau_pkg::frac_t frac_c;

	function automatic logic signed [32:0] sext(input logic [31:0] v);
		logic signed [32:0] r;
		r = 33'(signed'(v[OPERAND_WIDTH-1:0]));
		return r;
	endfunction

	assign in_stall = (state_q != S_IDLE);
	assign f_valid  = (state_q == S_OUT);
	assign f_data   = frac_c;

	// multiplier operand selection per step
	always_comb begin
		mx = an_q;
		my = bd_q;
		unique case (state_q)
			S_M0: begin
				mx = an_q;
				my = (op_q == rau_pkg::OP_MUL) ? bn_q : bd_q;
			end
			S_M1: begin
				mx = ad_q;
				my = (op_q == rau_pkg::OP_DIV) ? bn_q : bd_q;
			end
			S_M2: begin
				mx = bn_q;
				my = ad_q;
			end
			default: begin
				mx = an_q;
				my = bd_q;
			end
		endcase
	end

	assign prod = 66'(mx) * 66'(my);

	always_comb begin
		num_s = p0_q;
		case (op_q)
			rau_pkg::OP_ADD: num_s = p0_q + p2_q;
			rau_pkg::OP_SUB: num_s = p0_q - p2_q;
			default:         num_s = p0_q;
		endcase
		den_s = p1_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_M0;
				S_M0:   state_q <= S_M1;
				S_M1:   state_q <= (op_q[1]) ? S_OUT : S_M2;
				S_M2:   state_q <= S_OUT;
				S_OUT:  if (!f_stall) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			op_q <= in_data.op;
			an_q <= sext(in_data.a_num);
			ad_q <= sext(in_data.a_den);
			bn_q <= sext(in_data.b_num);
			bd_q <= sext(in_data.b_den);
			p2_q <= '0;
		end
		if (state_q == S_M0) p0_q <= prod;
		if (state_q == S_M1) p1_q <= prod;
		if (state_q == S_M2) p2_q <= prod;
	end

	// sign-magnitude fraction from the held products, steady while in S_OUT
	always_comb begin
		frac_c.neg     = num_s[65] ^ den_s[65];
		frac_c.num_mag = num_s[65] ? 64'(-num_s) : 64'(num_s);
		frac_c.den_mag = den_s[65] ? 64'(-den_s) : 64'(den_s);
	end

endmodule

FILE: hw/rtl/rau_queue.sv
// ----------------------------------------------------------------------------
// rau_queue - short FIFO between front and back
// Register-based, valid/stall on both sides.
// ----------------------------------------------------------------------------
module rau_queue #(
	parameter int DEPTH = rau_pkg::QueueDepthDefault
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           w_valid,
	output logic           w_stall,
	input  rau_pkg::frac_t w_data,
	output logic           r_valid,
	input  logic           r_stall,
	output rau_pkg::frac_t r_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	rau_pkg::frac_t mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0]   cnt_q;
	logic push, pop;

	assign w_stall = (cnt_q == (PW+1)'(DEPTH));
	assign r_valid = (cnt_q != '0);
	assign r_data  = mem_q[rp_q];
	assign push    = w_valid && !w_stall;
	assign pop     = r_valid && !r_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == PW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (pop)  rp_q <= (rp_q == PW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= w_data;
	end

endmodule

FILE: hw/rtl/rau_back.sv
// ----------------------------------------------------------------------------
// rau_back - gcd reduction and result formatting
// Binary gcd, then two restoring divisions one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               q_stall,
	input  rau_pkg::frac_t     q_data,
	output logic               out_valid,
	input  logic               out_stall,
	output rau_pkg::out_item_t out_data
);

	typedef enum logic [5:0] {
		B_IDLE = 6'b000001,
		B_GCD  = 6'b000010,
		B_DIVN = 6'b000100,
		B_DIVD = 6'b001000,
		B_FIN  = 6'b010000,
		B_OUT  = 6'b100000
	} bst_t;

	bst_t state_q;
	logic        neg_q;
	logic [63:0] nm_q, dm_q;    // original magnitudes
	logic [63:0] gx_q, gy_q;    // gcd working pair
	logic [5:0]  sh_q;          // common power of two
	logic [63:0] g_q;
	logic [63:0] quo_q, rem_q, nq_q;
	logic [5:0]  bit_q;
	logic [64:0] trial;
	logic        q_bit;
	logic [63:0] dividend;
	logic [63:0] diff;
	rau_pkg::out_item_t res_q;

	assign q_stall   = (state_q != B_IDLE);
	assign out_valid = (state_q == B_OUT);
	assign out_data  = res_q;

	assign dividend = (state_q == B_DIVN) ? nm_q : dm_q;
	assign trial    = {rem_q, dividend[bit_q]};
	assign q_bit    = (trial >= {1'b0, g_q});
	assign diff     = (gx_q > gy_q) ? gx_q - gy_q : gy_q - gx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			unique case (state_q)
				B_IDLE: if (q_valid) begin
					if (q_data.den_mag == '0 || q_data.num_mag == '0) state_q <= B_FIN;
					else state_q <= B_GCD;
				end
				B_GCD:  if (gx_q == gy_q) state_q <= B_DIVN;
				B_DIVN: if (bit_q == '0) state_q <= B_DIVD;
				B_DIVD: if (bit_q == '0) state_q <= B_FIN;
				B_FIN:  state_q <= B_OUT;
				B_OUT:  if (!out_stall) state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: if (q_valid) begin
				neg_q <= q_data.neg;
				nm_q  <= q_data.num_mag;
				dm_q  <= q_data.den_mag;
				gx_q  <= q_data.num_mag;
				gy_q  <= q_data.den_mag;
				sh_q  <= '0;
				bit_q <= 6'd63;
				rem_q <= '0;
			end
			B_GCD: begin
				// binary gcd: strip shared twos, strip lone twos, subtract
				if (gx_q == gy_q) begin
					g_q <= gx_q << sh_q;
				end else if (!gx_q[0] && !gy_q[0]) begin
					gx_q <= gx_q >> 1;
					gy_q <= gy_q >> 1;
					sh_q <= sh_q + 1'b1;
				end else if (!gx_q[0]) begin
					gx_q <= gx_q >> 1;
				end else if (!gy_q[0]) begin
					gy_q <= gy_q >> 1;
				end else if (gx_q > gy_q) begin
					gx_q <= diff;
				end else begin
					gy_q <= diff;
				end
			end
			B_DIVN, B_DIVD: begin
				quo_q <= {quo_q[62:0], q_bit};
				if (bit_q == '0) begin
					bit_q <= 6'd63;
					rem_q <= '0;
					if (state_q == B_DIVN) nq_q <= {quo_q[62:0], q_bit};
				end else begin
					bit_q <= bit_q - 1'b1;
					rem_q <= q_bit ? 64'(trial - {1'b0, g_q}) : trial[63:0];
				end
			end
			B_FIN: begin
				if (dm_q == '0) begin
					res_q <= '{res_num: '0, res_den: '0, status: rau_pkg::ST_ZERO_DEN};
				end else if (nm_q == '0) begin
					res_q <= '{res_num: '0, res_den: 63'd1, status: rau_pkg::ST_OK};
				end else if (!neg_q && nq_q[63]) begin
					res_q <= '{res_num: '0, res_den: '0, status: rau_pkg::ST_OVERFLOW};
				end else begin
					res_q.res_num <= neg_q ? -nq_q : nq_q;
					res_q.res_den <= quo_q[62:0];
					res_q.status  <= rau_pkg::ST_OK;
				end
			end
			default: ;
		endcase
	end

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");
	a_status_den: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != rau_pkg::ST_OK |-> out_data.res_den == '0)
		else $error("error result with nonzero denominator");
	a_one_job: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid && !q_stall |=> state_q != B_IDLE)
		else $error("accepted item lost");

endmodule
